// ----- hw/rtl/l2c_pkg.sv -----
// Shared constants, types and divider step functions for the LBA to CHS converter.
`default_nettype none
package l2c_pkg;

  localparam int ADDR_BITS = 32;
  localparam int DIV_STEP  = 4;
  localparam int STAGES    = (ADDR_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD_W     = STAGES * DIV_STEP;

  localparam int SPT_W = 8;
  localparam int SPC_W = 16;
  localparam int CYL_W = 10;
  localparam int HEAD_W = 8;
  localparam int SECT_W = 6;
  localparam int CFG_W = 16;

  localparam logic [SPT_W-1:0] SPT_RESET = 8'd63;
  localparam logic [SPC_W-1:0] SPC_RESET = 16'd16065;

  localparam logic REG_SPT = 1'b0;
  localparam logic REG_SPC = 1'b1;

  typedef struct packed {
    logic [SPC_W-1:0]    rem;
    logic [DIV_STEP-1:0] q;
  } cyl_step_t;

  typedef struct packed {
    logic [SPT_W-1:0]    rem;
    logic [DIV_STEP-1:0] q;
  } head_step_t;

  function automatic cyl_step_t cyl_step(input logic [SPC_W-1:0] rem,
                                         input logic [DIV_STEP-1:0] bits,
                                         input logic [SPC_W-1:0] den);
    logic [SPC_W:0] r;
    cyl_step_t res;
    r = {1'b0, rem};
    res.q = '0;
    for (int i = DIV_STEP - 1; i >= 0; i--) begin
      r = {r[SPC_W-1:0], bits[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        res.q[i] = 1'b1;
      end
    end
    res.rem = r[SPC_W-1:0];
    return res;
  endfunction

  function automatic head_step_t head_step(input logic [SPT_W-1:0] rem,
                                           input logic [DIV_STEP-1:0] bits,
                                           input logic [SPT_W-1:0] den);
    logic [SPT_W:0] r;
    head_step_t res;
    r = {1'b0, rem};
    res.q = '0;
    for (int i = DIV_STEP - 1; i >= 0; i--) begin
      r = {r[SPT_W-1:0], bits[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        res.q[i] = 1'b1;
      end
    end
    res.rem = r[SPT_W-1:0];
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/l2c_cyl_div.sv -----
// Pipelined divider: block address by sectors per cylinder, cylinder and remainder.
`default_nettype none
module l2c_cyl_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_vld,
  input  wire logic [l2c_pkg::ADDR_BITS-1:0]  in_addr,
  input  wire logic [l2c_pkg::SPC_W-1:0]      spc,
  output logic                                out_vld,
  output logic [l2c_pkg::CYL_W-1:0]           out_cyl,
  output logic [l2c_pkg::ADDR_BITS-1:0]       out_rest
);

  localparam int STG = l2c_pkg::STAGES;
  localparam int STP = l2c_pkg::DIV_STEP;
  localparam int PW  = l2c_pkg::PAD_W;

  logic [STG-1:0]                   vld_r;
  logic [STG-1:0]                   vld_nxt;
  logic [l2c_pkg::SPC_W-1:0]        rem_r   [STG];
  logic [l2c_pkg::SPC_W-1:0]        rem_nxt [STG];
  logic [l2c_pkg::CYL_W-1:0]        quo_r   [STG];
  logic [l2c_pkg::CYL_W-1:0]        quo_nxt [STG];
  logic [l2c_pkg::ADDR_BITS-1:0]    adr_r   [STG];
  logic [l2c_pkg::ADDR_BITS-1:0]    adr_nxt [STG];

  for (genvar s = 0; s < STG; s++) begin : g_stage
    logic [l2c_pkg::SPC_W-1:0]     rem_in;
    logic [l2c_pkg::CYL_W-1:0]     quo_in;
    logic [l2c_pkg::ADDR_BITS-1:0] adr_in;
    logic                          vld_in;
    logic [PW-1:0]                 num_pad;
    l2c_pkg::cyl_step_t            st;

    if (s == 0) begin : g_first
      assign vld_in = in_vld;
      assign rem_in = '0;
      assign quo_in = '0;
      assign adr_in = in_addr;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign adr_in = adr_r[s-1];
    end

    assign num_pad = PW'(adr_in);
    assign st      = l2c_pkg::cyl_step(rem_in, num_pad[PW-1-STP*s -: STP], spc);

    assign vld_nxt[s] = vld_in;
    assign rem_nxt[s] = st.rem;
    assign quo_nxt[s] = l2c_pkg::CYL_W'({quo_in, st.q});
    assign adr_nxt[s] = adr_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STG; s++) begin
      rem_r[s] <= rem_nxt[s];
      quo_r[s] <= quo_nxt[s];
      adr_r[s] <= adr_nxt[s];
    end
  end

  // zero divisor: all-ones quotient, dividend passes as remainder
  assign out_vld  = vld_r[STG-1];
  assign out_cyl  = (spc == '0) ? '1 : quo_r[STG-1];
  assign out_rest = (spc == '0) ? adr_r[STG-1] : l2c_pkg::ADDR_BITS'(rem_r[STG-1]);

endmodule
`default_nettype wire

// ----- hw/rtl/l2c_head_div.sv -----
// Pipelined divider: cylinder remainder by sectors per track, head and sector remainder.
`default_nettype none
module l2c_head_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_vld,
  input  wire logic [l2c_pkg::ADDR_BITS-1:0]  in_num,
  input  wire logic [l2c_pkg::CYL_W-1:0]      in_cyl,
  input  wire logic [l2c_pkg::SPT_W-1:0]      spt,
  output logic                                out_vld,
  output logic [l2c_pkg::HEAD_W-1:0]          out_head,
  output logic [l2c_pkg::SECT_W-1:0]          out_srem,
  output logic [l2c_pkg::CYL_W-1:0]           out_cyl
);

  localparam int STG = l2c_pkg::STAGES;
  localparam int STP = l2c_pkg::DIV_STEP;
  localparam int PW  = l2c_pkg::PAD_W;

  logic [STG-1:0]                   vld_r;
  logic [STG-1:0]                   vld_nxt;
  logic [l2c_pkg::SPT_W-1:0]        rem_r   [STG];
  logic [l2c_pkg::SPT_W-1:0]        rem_nxt [STG];
  logic [l2c_pkg::HEAD_W-1:0]       quo_r   [STG];
  logic [l2c_pkg::HEAD_W-1:0]       quo_nxt [STG];
  logic [l2c_pkg::ADDR_BITS-1:0]    num_r   [STG];
  logic [l2c_pkg::ADDR_BITS-1:0]    num_nxt [STG];
  logic [l2c_pkg::CYL_W-1:0]        cyl_r   [STG];
  logic [l2c_pkg::CYL_W-1:0]        cyl_nxt [STG];

  for (genvar s = 0; s < STG; s++) begin : g_stage
    logic [l2c_pkg::SPT_W-1:0]     rem_in;
    logic [l2c_pkg::HEAD_W-1:0]    quo_in;
    logic [l2c_pkg::ADDR_BITS-1:0] num_in;
    logic [l2c_pkg::CYL_W-1:0]     cyl_in;
    logic                          vld_in;
    logic [PW-1:0]                 num_pad;
    l2c_pkg::head_step_t           st;

    if (s == 0) begin : g_first
      assign vld_in = in_vld;
      assign rem_in = '0;
      assign quo_in = '0;
      assign num_in = in_num;
      assign cyl_in = in_cyl;
    end else begin : g_next
      assign vld_in = vld_r[s-1];
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
      assign num_in = num_r[s-1];
      assign cyl_in = cyl_r[s-1];
    end

    assign num_pad = PW'(num_in);
    assign st      = l2c_pkg::head_step(rem_in, num_pad[PW-1-STP*s -: STP], spt);

    assign vld_nxt[s] = vld_in;
    assign rem_nxt[s] = st.rem;
    assign quo_nxt[s] = l2c_pkg::HEAD_W'({quo_in, st.q});
    assign num_nxt[s] = num_in;
    assign cyl_nxt[s] = cyl_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STG; s++) begin
      rem_r[s] <= rem_nxt[s];
      quo_r[s] <= quo_nxt[s];
      num_r[s] <= num_nxt[s];
      cyl_r[s] <= cyl_nxt[s];
    end
  end

  // zero divisor: all-ones quotient, dividend passes as remainder
  assign out_vld  = vld_r[STG-1];
  assign out_head = (spt == '0) ? '1 : quo_r[STG-1];
  assign out_srem = (spt == '0) ? num_r[STG-1][l2c_pkg::SECT_W-1:0]
                                : rem_r[STG-1][l2c_pkg::SECT_W-1:0];
  assign out_cyl  = cyl_r[STG-1];

endmodule
`default_nettype wire

// ----- hw/rtl/lba_to_chs_mbr.sv -----
// Top level: linear block address to packed CHS bytes of a partition table entry.
//
// Usage:
//   Pulse start with in_block_address to submit one beat; busy is always low,
//   so a new beat may be submitted every clock cycle.
//   Each beat yields exactly one result, shown for one cycle with out_valid
//   high on out_cylinder_low, out_sector_byte and out_head_number.
//   Results appear in submission order.
//   A beat passes through two divider pipelines, retiring four quotient bits
//   per stage, and then the packing register. Throughput is one beat per cycle.
//   cfg_we writes cfg_data to register cfg_index (0: sectors per track,
//   1: sectors per cylinder); write only while no beat is in flight.
//   A zero divisor gives an all-ones quotient and passes the dividend on as
//   the remainder.
//   Reset (rst_n low, synchronous) empties the pipeline and loads 63 and
//   16065 into the two registers.
//   The receiver cannot stall: every result must be taken when out_valid
//   is high.
`default_nettype none
module lba_to_chs_mbr (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [31:0]                 in_block_address,
  output logic                             out_valid,
  output logic [7:0]                       out_cylinder_low,
  output logic [7:0]                       out_sector_byte,
  output logic [7:0]                       out_head_number,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [l2c_pkg::CFG_W-1:0]   cfg_data
);

  logic [l2c_pkg::SPT_W-1:0]       spt_r;
  logic [l2c_pkg::SPC_W-1:0]       spc_r;

  logic                            cyl_vld;
  logic [l2c_pkg::CYL_W-1:0]       cyl_q;
  logic [l2c_pkg::ADDR_BITS-1:0]   cyl_rest;

  logic                            hd_vld;
  logic [l2c_pkg::HEAD_W-1:0]      hd_head;
  logic [l2c_pkg::SECT_W-1:0]      hd_srem;
  logic [l2c_pkg::CYL_W-1:0]       hd_cyl;

  logic                            out_valid_r;
  logic [7:0]                      cyl_low_r;
  logic [7:0]                      sect_byte_r;
  logic [7:0]                      head_r;
  logic [l2c_pkg::SECT_W-1:0]      sect_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spt_r <= l2c_pkg::SPT_RESET;
      spc_r <= l2c_pkg::SPC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        l2c_pkg::REG_SPT: spt_r <= cfg_data[l2c_pkg::SPT_W-1:0];
        l2c_pkg::REG_SPC: spc_r <= cfg_data[l2c_pkg::SPC_W-1:0];
        default: ;
      endcase
    end
  end

  l2c_cyl_div u_cyl_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start),
    .in_addr  (in_block_address[l2c_pkg::ADDR_BITS-1:0]),
    .spc      (spc_r),
    .out_vld  (cyl_vld),
    .out_cyl  (cyl_q),
    .out_rest (cyl_rest)
  );

  l2c_head_div u_head_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (cyl_vld),
    .in_num   (cyl_rest),
    .in_cyl   (cyl_q),
    .spt      (spt_r),
    .out_vld  (hd_vld),
    .out_head (hd_head),
    .out_srem (hd_srem),
    .out_cyl  (hd_cyl)
  );

  assign sect_nxt = hd_srem + l2c_pkg::SECT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= hd_vld;
    end
  end

  always_ff @(posedge clk) begin
    cyl_low_r   <= hd_cyl[7:0];
    sect_byte_r <= {hd_cyl[9:8], sect_nxt};
    head_r      <= hd_head;
  end

  assign out_valid        = out_valid_r;
  assign out_cylinder_low = cyl_low_r;
  assign out_sector_byte  = sect_byte_r;
  assign out_head_number  = head_r;

endmodule
`default_nettype wire
